// ----- sv/gss_pkg.sv -----
// ----------------------------------------------------------------------------
// Gripper search-and-grip sequencer package
// Shared types, phase codes, message bytes and command codes.
// ----------------------------------------------------------------------------
package gss_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int MAX_RES        = 6;
    localparam int CNT_W          = 3;
    localparam int DB_W           = 10;
    localparam int NUM_SW         = 3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_LOWER  = 4'd1,
        PH_HIGHER = 4'd2,
        PH_RIGHT  = 4'd3,
        PH_MID    = 4'd4,
        PH_EDGE   = 4'd5,
        PH_MOVLOW = 4'd6,
        PH_CLOSE  = 4'd7,
        PH_WAITCL = 4'd8,
        PH_DONE   = 4'd9,
        PH_FAIL   = 4'd10
    } phase_t;

    localparam logic [7:0] MSG_HIT    = 8'h20;
    localparam logic [7:0] MSG_HIGHER = 8'h21;
    localparam logic [7:0] MSG_RIGHT  = 8'h22;
    localparam logic [7:0] MSG_EDGE   = 8'h23;
    localparam logic [7:0] MSG_OK     = 8'h06;
    localparam logic [7:0] MSG_FAIL   = 8'h07;
    localparam logic [7:0] IR_UPPER   = 8'h01;
    localparam logic [7:0] IR_LOWER   = 8'h00;

    localparam logic [7:0] CMD_DONE   = 8'h00;
    localparam logic [7:0] CMD_START  = 8'h01;
    localparam logic [7:0] CMD_RESET  = 8'h03;

    localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] CFG_CLOSE_WAIT = 2'd1;
    localparam logic [1:0] CFG_MAX_TRIES  = 2'd2;

    localparam logic [9:0]  DEBOUNCE_RST   = 10'd100;
    localparam logic [15:0] CLOSE_WAIT_RST = 16'd5000;
    localparam logic [3:0]  MAX_TRIES_RST  = 4'd2;

    typedef struct packed {
        logic       close_switch;
        logic       lower_limit;
        logic       central_limit;
        logic       upper_limit;
        logic       lower_ir;
        logic       upper_ir;
        logic [7:0] cmd_byte;
    } item_t;

    typedef struct packed {
        logic [3:0]  max_tries;
        logic [15:0] close_wait;
        logic [9:0]  debounce;
    } cfg_t;

    typedef struct packed {
        phase_t                       phase;
        logic                         host_done;
        logic                         upper_rep;
        logic                         lower_rep;
        logic [3:0]                   tries;
        logic [NUM_SW-1:0][DB_W-1:0]  db_cnt;
        logic [NUM_SW-1:0]            db_act;
        logic                         valve;
        logic                         led;
    } state_t;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    valve;
        logic                    led;
        phase_t                  phase;
    } record_t;

endpackage

// ----- sv/gss_step.sv -----
// ----------------------------------------------------------------------------
// Gripper sequencer step logic
// Next state, valve timer and message bytes for one tick or command.
// ----------------------------------------------------------------------------
module gss_step
    import gss_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                  func,
    input  item_t                 item,
    input  cfg_t                  cfg,
    input  state_t                st,
    input  logic [TIMER_BITS-1:0] timer,
    output state_t                st_out,
    output logic [TIMER_BITS-1:0] timer_out,
    output record_t               rec
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [TIMER_BITS-1:0] tm_inc;
    logic                  tm_ge;
    logic [NUM_SW-1:0]     limits;

    assign tm_inc = (timer == '1) ? timer : timer + 1'b1;
    assign tm_ge  = CMP_W'(tm_inc) >= CMP_W'(cfg.close_wait);
    assign limits = {item.lower_limit, item.central_limit, item.upper_limit};

    always_comb
    begin
        state_t                  ns;
        logic [TIMER_BITS-1:0]   tn;
        logic [MAX_RES-1:0][7:0] em;
        logic [CNT_W-1:0]        cnt;

        ns  = st;
        tn  = timer;
        em  = '0;
        cnt = '0;

        if (func)
        begin
            case (item.cmd_byte)
                CMD_DONE:  ns.host_done = 1'b1;
                CMD_START: ns.phase     = PH_LOWER;
                CMD_RESET: ns.phase     = PH_IDLE;
                default:   ;
            endcase
        end
        else
        begin
            tn = tm_inc;
            case (st.phase)
                PH_IDLE:
                begin
                    ns.valve     = 1'b1;
                    ns.host_done = 1'b0;
                    ns.upper_rep = 1'b0;
                    ns.lower_rep = 1'b0;
                    ns.tries     = '0;
                end
                PH_LOWER:
                begin
                    ns.led = 1'b0;
                    for (int k = 0; k < NUM_SW; k++)
                    begin
                        if (!limits[k])
                        begin
                            ns.db_act[k] = 1'b0;
                        end
                        else if (!st.db_act[k])
                        begin
                            ns.db_act[k] = 1'b1;
                            ns.db_cnt[k] = '0;
                        end
                        else
                        begin
                            if (st.db_cnt[k] != '1)
                            begin
                                ns.db_cnt[k] = st.db_cnt[k] + 1'b1;
                            end
                            if (ns.db_cnt[k] >= cfg.debounce)
                            begin
                                ns.phase = PH_HIGHER;
                                em[cnt]  = MSG_HIGHER;
                                cnt      = cnt + 1'b1;
                                em[cnt]  = 8'(k);
                                cnt      = cnt + 1'b1;
                            end
                        end
                    end
                end
                PH_HIGHER, PH_MID:
                begin
                    if (st.host_done)
                    begin
                        ns.phase     = (st.phase == PH_HIGHER) ? PH_RIGHT : PH_EDGE;
                        ns.host_done = 1'b0;
                    end
                end
                PH_RIGHT, PH_EDGE:
                begin
                    if (item.upper_ir && !st.upper_rep)
                    begin
                        ns.upper_rep = 1'b1;
                        em[cnt]      = MSG_HIT;
                        cnt          = cnt + 1'b1;
                        em[cnt]      = IR_UPPER;
                        cnt          = cnt + 1'b1;
                    end
                    if (item.lower_ir && !st.lower_rep)
                    begin
                        ns.lower_rep = 1'b1;
                        em[cnt]      = MSG_HIT;
                        cnt          = cnt + 1'b1;
                        em[cnt]      = IR_LOWER;
                        cnt          = cnt + 1'b1;
                    end
                    if (st.phase == PH_RIGHT)
                    begin
                        if (ns.upper_rep && ns.lower_rep)
                        begin
                            ns.phase     = PH_MID;
                            ns.upper_rep = 1'b0;
                            ns.lower_rep = 1'b0;
                            em[cnt]      = MSG_RIGHT;
                            cnt          = cnt + 1'b1;
                        end
                    end
                    else if (ns.upper_rep || ns.lower_rep)
                    begin
                        ns.phase = PH_MOVLOW;
                        em[cnt]  = MSG_EDGE;
                        cnt      = cnt + 1'b1;
                    end
                end
                PH_MOVLOW:
                begin
                    if (limits != '0)
                    begin
                        ns.phase = PH_FAIL;
                        em[cnt]  = MSG_FAIL;
                        cnt      = cnt + 1'b1;
                    end
                    else if (st.host_done)
                    begin
                        ns.host_done = 1'b0;
                        ns.phase     = PH_CLOSE;
                    end
                end
                PH_CLOSE:
                begin
                    if (tm_ge)
                    begin
                        ns.valve = 1'b0;
                        ns.phase = PH_WAITCL;
                        tn       = '0;
                    end
                    if (st.tries >= cfg.max_tries)
                    begin
                        ns.phase = PH_FAIL;
                        em[cnt]  = MSG_FAIL;
                        cnt      = cnt + 1'b1;
                    end
                end
                PH_WAITCL:
                begin
                    if (tm_ge)
                    begin
                        if (item.close_switch)
                        begin
                            ns.phase = PH_DONE;
                            em[cnt]  = MSG_OK;
                            cnt      = cnt + 1'b1;
                        end
                        else
                        begin
                            ns.valve = 1'b1;
                            ns.phase = PH_CLOSE;
                            tn       = '0;
                            if (st.tries != '1)
                            begin
                                ns.tries = st.tries + 1'b1;
                            end
                        end
                    end
                end
                PH_DONE, PH_FAIL:
                begin
                    ns.led = 1'b1;
                end
                default:
                begin
                    ns.phase = PH_IDLE;
                end
            endcase
        end

        st_out    = ns;
        timer_out = tn;
        rec.bytes = em;
        rec.count = cnt;
        rec.valve = ns.valve;
        rec.led   = ns.led;
        rec.phase = ns.phase;
    end

endmodule

// ----- sv/gripper_search_grip_sequencer.sv -----
// ----------------------------------------------------------------------------
// Gripper search-and-grip sequencer
// Top level: input stage, sequencer state, result record and byte serializer.
// ----------------------------------------------------------------------------
// Each input transaction is either a 1 ms tick carrying the sensor levels
// (s_tuser low) or a received host command byte (s_tuser high). A command only
// changes the phase or the host-done flag; the sequencer acts on it at the
// next tick. Every input transaction yields one to six output transactions:
// one per message byte for the host, or a single transaction with m_tuser low
// when no byte is due. m_tlast marks the last output of an input, and every
// output of an input carries the valve, LED and phase levels as they stand
// after that input. An accepted input is held in the input register, then
// the step logic updates the state and loads the result record, and the
// serializer drives the record out one byte per cycle while m_tready is
// high. The output port sets the rate, so inputs with a single result flow
// at one per cycle while m_tready is high. While a finished record still
// waits to be taken, the input register can take one more transaction; the
// input then stalls until the last output of that record leaves. The
// configuration registers are written through cfg_we, cfg_addr and
// cfg_wdata; the user must write them while the block is idle, which the
// block does not enforce itself; writes to index 3 are dropped.
module gripper_search_grip_sequencer
    import gss_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata from bit 0: cmd_byte[7:0], upper_ir, lower_ir, upper_limit,
    // central_limit, lower_limit, close_switch, two unused bits.
    input  logic [15:0] s_tdata,
    // s_tuser: func (0 tick, 1 command byte).
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0: tx_byte[7:0], valve_drive, led_on, phase[3:0],
    // two zero bits.
    output logic [15:0] m_tdata,
    // m_tuser: has_byte.
    output logic        m_tuser,
    // m_tlast: last_result.
    output logic        m_tlast
);

    cfg_t                  cfg_reg;
    logic                  in_valid_reg;
    logic                  in_func_reg;
    item_t                 in_item_reg;
    state_t                st_reg;
    state_t                st_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] timer_next;
    logic                  rec_valid_reg;
    record_t               rec_reg;
    record_t               rec_next;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      last_idx;
    logic                  out_take;
    logic                  rec_done;
    logic                  fire;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce   <= DEBOUNCE_RST;
            cfg_reg.close_wait <= CLOSE_WAIT_RST;
            cfg_reg.max_tries  <= MAX_TRIES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DEBOUNCE:   cfg_reg.debounce   <= cfg_wdata[9:0];
                CFG_CLOSE_WAIT: cfg_reg.close_wait <= cfg_wdata;
                CFG_MAX_TRIES:  cfg_reg.max_tries  <= cfg_wdata[3:0];
                default:        ;
            endcase
        end
    end

    // The serializer is done with a record when its last byte is taken.
    assign out_take = m_tvalid && m_tready;
    assign last_idx = (rec_reg.count == '0) ? '0 : rec_reg.count - 1'b1;
    assign rec_done = out_take && m_tlast;

    // The step fires when the input register holds an item and the record
    // register is free or being emptied in this cycle.
    assign fire     = in_valid_reg && (!rec_valid_reg || rec_done);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_func_reg <= s_tuser;
            in_item_reg <= s_tdata[13:0];
        end
    end

    gss_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .func      (in_func_reg),
        .item      (in_item_reg),
        .cfg       (cfg_reg),
        .st        (st_reg),
        .timer     (timer_reg),
        .st_out    (st_next),
        .timer_out (timer_next),
        .rec       (rec_next)
    );

    // Sequencer state and valve timer advance once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase     <= PH_IDLE;
            st_reg.host_done <= 1'b0;
            st_reg.upper_rep <= 1'b0;
            st_reg.lower_rep <= 1'b0;
            st_reg.tries     <= '0;
            st_reg.db_cnt    <= '0;
            st_reg.db_act    <= '0;
            st_reg.valve     <= 1'b1;
            st_reg.led       <= 1'b0;
            timer_reg        <= '1;
        end
        else if (fire)
        begin
            st_reg    <= st_next;
            timer_reg <= timer_next;
        end
    end

    // Result record and byte index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (fire)
        begin
            rec_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end
        else if (rec_done)
        begin
            rec_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (out_take)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rec_reg <= rec_next;
        end
    end

    assign m_tvalid = rec_valid_reg;
    assign m_tuser  = rec_reg.count != '0;
    assign m_tlast  = idx_reg == last_idx;
    assign m_tdata  = {2'b00, rec_reg.phase, rec_reg.led, rec_reg.valve,
                       rec_reg.bytes[idx_reg]};

endmodule
